### hdl/gsa_pkg.sv
`default_nettype none

package gsa_pkg;

  // Slot and field geometry. The number of slots fixes the handle index field
  // at six bits; the generation field fixes the generation width.
  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CAP_W      = IDX_W + 1;
  localparam int GEN_W      = 16;
  localparam int ACTIVE_W   = 7;

  localparam logic [GEN_W-1:0]    GEN_RESET    = GEN_W'(1);
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(64);

  // Operation codes.
  localparam logic [2:0] KIND_OPEN  = 3'd0;
  localparam logic [2:0] KIND_CLOSE = 3'd1;
  localparam logic [2:0] KIND_CHECK = 3'd2;
  localparam logic [2:0] KIND_NEXT  = 3'd3;
  localparam logic [2:0] KIND_PREV  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef logic [SLOT_COUNT-1:0] slot_map_t;

  // Outcome of the bitmap search for one operation.
  typedef struct packed {
    logic             any;
    logic [IDX_W-1:0] slot;
    logic             handle_ok;
  } find_t;

  function automatic logic [IDX_W-1:0] lowest_set(input slot_map_t v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] highest_set(input slot_map_t v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/generational_slot_allocator.sv
`default_nettype none

// Generational slot allocator. Hands out handles made of a slot index and a
// generation over slots 1 to capacity-1, where capacity is the active_slots
// register limited to 64 and index zero stands for no handle. Open takes the
// first free slot at or after the free hint (wrapping), close frees a slot
// whose handle matches and advances its generation, check only validates, and
// next and previous walk over the occupied slots. Each request transfer gives
// exactly one response transfer. In the cycle of a request's transfer the
// occupancy bitmap is searched and the generation memory is read; then, in
// the response state and once the response side can take a response, the
// read word is compared, written back on a close and the response register
// is loaded. Only after that does the block return to idle and take the
// next request, so it never works on two requests at once. A write to the
// configuration register is followed by a re-alignment of the free hint to
// the new capacity by repeated subtraction, one step a cycle, at most 63
// steps, during which no request is taken.
module generational_slot_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration register write channel.
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [gsa_pkg::ACTIVE_W-1:0] cfg_active_slots,
  // Request channel.
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire logic [2:0]                   kind,
  input  wire logic [gsa_pkg::IDX_W-1:0]    handle_index,
  input  wire logic [gsa_pkg::GEN_W-1:0]    handle_generation,
  // Response channel.
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output logic [1:0]                        status,
  output logic [gsa_pkg::IDX_W-1:0]         result_index,
  output logic [gsa_pkg::GEN_W-1:0]         result_generation,
  output logic [gsa_pkg::IDX_W-1:0]         used_count
);
  import gsa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RESP
  } state_t;

  state_t state;

  // Allocator state held in flip-flops: the occupancy bitmap, the running
  // count of occupied slots, the free hint and the capacity register.
  slot_map_t           occupied_map;
  logic [IDX_W-1:0]    occupied_total;
  logic [CAP_W-1:0]    hint;
  logic [CAP_W-1:0]    reduced;
  logic [ACTIVE_W-1:0] active_slots;
  logic [CAP_W-1:0]    cap;

  // The request being worked on.
  logic [2:0]          op_kind;
  logic [IDX_W-1:0]    op_index;
  logic [GEN_W-1:0]    op_generation;
  find_t               op_find;

  logic [IDX_W-1:0]    open_start;
  find_t               find;
  logic                req_xfer;
  logic                finish;
  logic [IDX_W-1:0]    rd_addr;
  logic [GEN_W-1:0]    gen_now;
  logic                gen_match;
  logic                open_do;
  logic                close_do;
  logic [1:0]          status_next;
  logic [IDX_W-1:0]    result_index_next;
  logic [GEN_W-1:0]    result_generation_next;
  logic [IDX_W-1:0]    used_count_next;

  assign cap = (CAP_W'(active_slots) > CAP_W'(SLOT_COUNT)) ? CAP_W'(SLOT_COUNT)
                                                           : CAP_W'(active_slots);

  // The open search starts at the hint folded into the slot range. A hint
  // above the capacity can only be left behind by a capacity change, and its
  // folded value is prepared after the configuration write. A hint equal to
  // the capacity folds to the first slot.
  always_comb begin
    if (hint < cap) begin
      open_start = hint[IDX_W-1:0];
    end else if (hint == cap) begin
      open_start = IDX_W'(1);
    end else begin
      open_start = reduced[IDX_W-1:0];
    end
  end

  gsa_slot_finder u_finder (
    .occupied     (occupied_map),
    .cap          (cap),
    .open_start   (open_start),
    .kind         (kind),
    .handle_index (handle_index),
    .find         (find)
  );

  assign req_ready = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state != ST_RESP);
  assign req_xfer  = req_valid && req_ready;
  assign finish    = (state == ST_RESP) && (!rsp_valid || rsp_ready);

  // Close and check look up the generation of the given slot; the other
  // operations fetch the generation of the slot that the search found.
  assign rd_addr = ((kind == KIND_CLOSE) || (kind == KIND_CHECK)) ? handle_index : find.slot;

  gsa_gen_store u_gen_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (req_xfer),
    .rd_addr (rd_addr),
    .wr_en   (finish && close_do),
    .wr_addr (op_index),
    .wr_data (gen_now + GEN_W'(1)),
    .rd_data (gen_now)
  );

  assign gen_match = (gen_now == op_generation);

  // Result and state update of the request in the response cycle.
  always_comb begin
    status_next            = ST_BAD;
    result_index_next      = '0;
    result_generation_next = '0;
    open_do                = 1'b0;
    close_do               = 1'b0;
    case (op_kind)
      KIND_OPEN: begin
        if (op_find.any) begin
          status_next            = ST_OK;
          result_index_next      = op_find.slot;
          result_generation_next = gen_now;
          open_do                = 1'b1;
        end else begin
          status_next = ST_NONE;
        end
      end
      KIND_CLOSE: begin
        if (op_find.handle_ok && gen_match) begin
          status_next = ST_OK;
          close_do    = 1'b1;
        end
      end
      KIND_CHECK: begin
        if (op_find.handle_ok && gen_match) begin
          status_next            = ST_OK;
          result_index_next      = op_index;
          result_generation_next = op_generation;
        end
      end
      KIND_NEXT, KIND_PREV: begin
        if (op_find.any) begin
          status_next            = ST_OK;
          result_index_next      = op_find.slot;
          result_generation_next = gen_now;
        end else begin
          status_next = ST_NONE;
        end
      end
      default: begin
        status_next = ST_BAD;
      end
    endcase
    used_count_next = occupied_total + IDX_W'(open_do) - IDX_W'(close_do);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      rsp_valid      <= 1'b0;
      occupied_map   <= '0;
      occupied_total <= '0;
      hint           <= CAP_W'(1);
      reduced        <= CAP_W'(1);
      active_slots   <= ACTIVE_RESET;
    end else begin
      // A new response replaces the one leaving in the same cycle.
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // A configuration write is never taken in the response cycle, so it
      // only ever interrupts an idle or re-aligning block.
      if (cfg_valid && cfg_ready) begin
        active_slots <= cfg_active_slots;
        reduced      <= hint;
        state        <= ST_REDUCE;
      end else begin
        case (state)
          ST_IDLE: begin
            if (req_xfer) begin
              op_kind       <= kind;
              op_index      <= handle_index;
              op_generation <= handle_generation;
              op_find       <= find;
              state         <= ST_RESP;
            end
          end
          ST_REDUCE: begin
            // Fold the hint into 1..capacity-1, one subtraction a cycle.
            if ((reduced >= cap) && (cap >= CAP_W'(2))) begin
              reduced <= reduced - (cap - CAP_W'(1));
            end else begin
              state <= ST_IDLE;
            end
          end
          ST_RESP: begin
            if (finish) begin
              status            <= status_next;
              result_index      <= result_index_next;
              result_generation <= result_generation_next;
              used_count        <= used_count_next;
              occupied_total    <= used_count_next;
              if (open_do) begin
                occupied_map[op_find.slot] <= 1'b1;
                hint                       <= CAP_W'(op_find.slot) + CAP_W'(1);
              end
              if (close_do) begin
                occupied_map[op_index] <= 1'b0;
                if (CAP_W'(op_index) < hint) hint <= CAP_W'(op_index);
              end
              state <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_matches_map: assert property (@(posedge clk) disable iff (rst)
    $countones(occupied_map) == int'(occupied_total))
    else $error("occupied count differs from the bitmap");

  a_slot_zero_free: assert property (@(posedge clk) disable iff (rst)
    !occupied_map[0])
    else $error("reserved slot zero marked occupied");

  a_hint_bounded: assert property (@(posedge clk) disable iff (rst)
    hint <= CAP_W'(SLOT_COUNT) && hint != '0)
    else $error("free hint out of range");

  a_request_then_response: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> state == ST_RESP && !req_ready)
    else $error("request transfer not followed by its response cycle");

  a_response_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_RESP && rsp_valid && !rsp_ready |=> state == ST_RESP)
    else $error("pending response overwritten");
`endif

endmodule

`default_nettype wire

### hdl/gsa_gen_store.sv
`default_nettype none

module gsa_gen_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [gsa_pkg::IDX_W-1:0] rd_addr,
  input  wire logic                      wr_en,
  input  wire logic [gsa_pkg::IDX_W-1:0] wr_addr,
  input  wire logic [gsa_pkg::GEN_W-1:0] wr_data,
  output logic      [gsa_pkg::GEN_W-1:0] rd_data
);
  import gsa_pkg::*;

  logic [GEN_W-1:0]      gen_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written;
  logic [GEN_W-1:0]      rd_word;
  logic                  rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) gen_mem[wr_addr] <= wr_data;
    if (rd_en) rd_word <= gen_mem[rd_addr];
  end

  // An entry that has never been written holds the reset generation.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) written[wr_addr] <= 1'b1;
      if (rd_en) rd_written <= written[rd_addr];
    end
  end

  assign rd_data = rd_written ? rd_word : GEN_RESET;

endmodule

`default_nettype wire

### hdl/gsa_slot_finder.sv
`default_nettype none

module gsa_slot_finder (
  input  wire gsa_pkg::slot_map_t         occupied,
  input  wire logic [gsa_pkg::CAP_W-1:0]  cap,
  input  wire logic [gsa_pkg::IDX_W-1:0]  open_start,
  input  wire logic [2:0]                 kind,
  input  wire logic [gsa_pkg::IDX_W-1:0]  handle_index,
  output gsa_pkg::find_t                  find
);
  import gsa_pkg::*;

  slot_map_t        in_range;
  slot_map_t        used;
  slot_map_t        free_slots;
  slot_map_t        below;
  slot_map_t        cand_hi;
  slot_map_t        cand_all;
  logic [CAP_W-1:0] next_start;
  logic             handle_ok;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      in_range[i] = (i != 0) && (CAP_W'(i) < cap);
    end
    used       = occupied & in_range;
    free_slots = ~occupied & in_range;
    handle_ok  = in_range[handle_index] && occupied[handle_index];
    next_start = (handle_index == '0) ? CAP_W'(1) : CAP_W'(handle_index) + CAP_W'(1);
    below      = handle_ok ? (used & ((slot_map_t'(1) << handle_index) - slot_map_t'(1)))
                           : '0;

    find.handle_ok = handle_ok;
    find.any       = 1'b0;
    find.slot      = '0;
    cand_hi        = '0;
    cand_all       = '0;

    case (kind)
      KIND_OPEN: begin
        cand_hi   = free_slots & ({SLOT_COUNT{1'b1}} << open_start);
        cand_all  = free_slots;
        find.any  = |cand_all;
        find.slot = (|cand_hi) ? lowest_set(cand_hi) : lowest_set(cand_all);
      end
      KIND_NEXT: begin
        cand_hi   = used & ({SLOT_COUNT{1'b1}} << next_start);
        cand_all  = used;
        find.any  = |cand_all;
        find.slot = (|cand_hi) ? lowest_set(cand_hi) : lowest_set(cand_all);
      end
      KIND_PREV: begin
        // Nearest used slot below an occupied index, else the last used one.
        cand_hi   = below;
        cand_all  = used;
        find.any  = |cand_all;
        find.slot = (|cand_hi) ? highest_set(cand_hi) : highest_set(cand_all);
      end
      default: begin
        find.any  = 1'b0;
        find.slot = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

// The testbench drives three channels of the generational slot allocator:
// the configuration write channel for the active_slots register, the request
// channel and the response channel. Every request transfer is answered by
// exactly one response transfer, so each accepted request pushes one expected
// response onto a queue. Each response transfer is compared, field by field,
// with the oldest entry of that queue. The expected responses come from a
// behavioural copy of the allocator held in this module, which keeps its own
// occupancy map, generation memory, free hint, used count and register copy.
module tb_top;
  import gsa_pkg::*;

  // Kind codes that the block does not decode, used to exercise its
  // rejection path.
  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

  localparam logic [GEN_W-1:0] GEN_TOP = '1;

  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the deliberate response hold-off below, well
  // short of this figure.
  localparam int STALL_LIMIT     = 2000;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 10;

  // One response as the block presents it.
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot;
    logic [GEN_W-1:0] gen;
    logic [IDX_W-1:0] count;
  } resp_t;

  // One line of the directed script: either a register write or a request,
  // with the response typed in where it is obvious.
  typedef struct packed {
    logic                is_setting;
    logic [ACTIVE_W-1:0] setting;
    logic [2:0]          op;
    logic [IDX_W-1:0]    idx;
    logic [GEN_W-1:0]    gen;
    logic                typed;
    resp_t               want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ACTIVE_W-1:0] cfg_active_slots = '0;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic [2:0]          kind = KIND_OPEN;
  logic [IDX_W-1:0]    handle_index = '0;
  logic [GEN_W-1:0]    handle_generation = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  logic [1:0]          status;
  logic [IDX_W-1:0]    result_index;
  logic [GEN_W-1:0]    result_generation;
  logic [IDX_W-1:0]    used_count;

  generational_slot_allocator uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioural copy of the allocator state.
  logic                slot_busy [SLOT_COUNT];
  logic [GEN_W-1:0]    slot_gen [SLOT_COUNT];
  int                  free_hint_copy;
  logic [IDX_W-1:0]    busy_total;
  logic [ACTIVE_W-1:0] active_setting;

  resp_t       expected_responses [$];
  script_row_t script [$];
  resp_t       oldest;
  int          fault_count = 0;

  // Idle rates in percent, set by the main sequence for each part of the run.
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  rsp_hold_request = 1'b0;

  // Settings for the random part, one entry per phase. The list includes the
  // clamped maximum, the smallest legal capacity and the two values below it
  // at which no slot can be used at all.
  int phase_setting [8] = '{64, 9, 127, 2, 37, 1, 0, 64};
  int phase_items [8]   = '{300, 300, 300, 250, 300, 100, 100, 350};

  // The register is clamped to the number of physical slots.
  function automatic int capacity_now();
    return (int'(active_setting) > SLOT_COUNT) ? SLOT_COUNT : int'(active_setting);
  endfunction

  // Works out the response to one request and applies its effect to the
  // behavioural state. Slots at or above the capacity stay counted but are
  // invisible to every operation.
  function automatic resp_t compute_response(input logic [2:0] op,
                                             input logic [IDX_W-1:0] hi,
                                             input logic [GEN_W-1:0] hg);
    resp_t r;
    int    cap;
    int    found;
    int    c;
    bit    handle_ok;
    bit    stop;
    cap = capacity_now();
    found = 0;
    stop = 1'b0;
    r = '0;
    r.status = ST_BAD;
    handle_ok = (hi != '0) && (int'(hi) < cap) && slot_busy[hi] && (slot_gen[hi] == hg);
    case (op)
      KIND_OPEN: begin
        // Circular search from the hint over slots 1 to cap-1.
        for (int s = 1; s < cap; s++) begin
          c = free_hint_copy + s - 1;
          if (c >= cap) c = 1 + (c - 1) % (cap - 1);
          if (found == 0 && !slot_busy[c]) found = c;
        end
        if (found == 0) begin
          r.status = ST_NONE;
        end else begin
          slot_busy[found] = 1'b1;
          busy_total = busy_total + 1'b1;
          free_hint_copy = found + 1;
          r.status = ST_OK;
          r.slot = IDX_W'(found);
          r.gen = slot_gen[found];
        end
      end
      KIND_CLOSE: begin
        if (handle_ok) begin
          slot_busy[hi] = 1'b0;
          slot_gen[hi] = slot_gen[hi] + 1'b1;
          busy_total = busy_total - 1'b1;
          if (int'(hi) < free_hint_copy) free_hint_copy = int'(hi);
          r.status = ST_OK;
        end
      end
      KIND_CHECK: begin
        if (handle_ok) begin
          r.status = ST_OK;
          r.slot = hi;
          r.gen = hg;
        end
      end
      KIND_NEXT, KIND_PREV: begin
        if (op == KIND_NEXT) begin
          for (int s = (hi == '0) ? 1 : int'(hi) + 1; s < cap; s++) begin
            if (found == 0 && slot_busy[s]) found = s;
          end
          for (int s = 1; s < cap; s++) begin
            if (found == 0 && slot_busy[s]) found = s;
          end
        end else begin
          // Nearest used slot below the given one, provided the given one
          // is itself used; otherwise the last used slot.
          for (int s = 1; s < cap; s++) begin
            if (!stop && slot_busy[s]) begin
              if (s == int'(hi)) stop = 1'b1;
              else found = s;
            end
          end
          for (int s = cap - 1; s >= 1; s--) begin
            if (found == 0 && slot_busy[s]) found = s;
          end
        end
        if (found == 0) begin
          r.status = ST_NONE;
        end else begin
          r.status = ST_OK;
          r.slot = IDX_W'(found);
          r.gen = slot_gen[found];
        end
      end
      default: begin
      end
    endcase
    r.count = busy_total;
    return r;
  endfunction

  function automatic script_row_t request_row(input logic [2:0] op,
                                              input logic [IDX_W-1:0] hi,
                                              input logic [GEN_W-1:0] hg);
    script_row_t row;
    row = '0;
    row.op = op;
    row.idx = hi;
    row.gen = hg;
    return row;
  endfunction

  function automatic script_row_t known_row(input logic [2:0] op,
                                            input logic [IDX_W-1:0] hi,
                                            input logic [GEN_W-1:0] hg,
                                            input logic [1:0] st,
                                            input logic [IDX_W-1:0] ri,
                                            input logic [GEN_W-1:0] rg,
                                            input logic [IDX_W-1:0] cnt);
    script_row_t row;
    row = request_row(op, hi, hg);
    row.typed = 1'b1;
    row.want = '{status: st, slot: ri, gen: rg, count: cnt};
    return row;
  endfunction

  function automatic script_row_t setting_row(input logic [ACTIVE_W-1:0] v);
    script_row_t row;
    row = '0;
    row.is_setting = 1'b1;
    row.setting = v;
    return row;
  endfunction

  // Offers one request, starting at a falling edge, and returns at the
  // falling edge after its transfer. A random gap may come first; once valid
  // is raised it is held with the payload steady until the transfer.
  task automatic offer(input logic [2:0] op, input logic [IDX_W-1:0] hi,
                       input logic [GEN_W-1:0] hg, input logic typed,
                       input resp_t want);
    resp_t r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid         <= 1'b1;
    kind              <= op;
    handle_index      <= hi;
    handle_generation <= hg;
    do @(posedge clk); while (!req_ready);
    // The behavioural state always advances, even where the expected
    // response has been typed in by hand.
    r = compute_response(op, hi, hg);
    expected_responses.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // Register writes happen only with nothing in flight. The block then
  // re-aligns its hint before it takes the next request, which the request
  // handshake absorbs.
  task automatic write_active(input logic [ACTIVE_W-1:0] v);
    req_valid <= 1'b0;
    while (expected_responses.size() != 0) @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_active_slots <= v;
    do @(posedge clk); while (!cfg_ready);
    active_setting = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Chooses a random request. Most closes and checks carry a live handle so
  // that the occupancy and generation logic is exercised deeply; the rest
  // are stale, out of range or plain noise.
  task automatic choose_request(output logic [2:0] op, output logic [IDX_W-1:0] hi,
                                output logic [GEN_W-1:0] hg);
    int live [$];
    int cap;
    int pick;
    int open_weight;
    cap = capacity_now();
    for (int s = 1; s < cap; s++) begin
      if (slot_busy[s]) live.push_back(s);
    end
    open_weight = (live.size() * 4 > cap * 3) ? 15 : 35;
    pick = $urandom_range(99);
    hi = IDX_W'($urandom_range(SLOT_COUNT - 1));
    hg = GEN_W'($urandom);
    if (pick < open_weight) begin
      op = KIND_OPEN;
    end else if (pick < open_weight + 63) begin
      if (pick < open_weight + 30) op = KIND_CLOSE;
      else if (pick < open_weight + 45) op = KIND_CHECK;
      else if (pick < open_weight + 52) op = KIND_NEXT;
      else if (pick < open_weight + 59) op = KIND_PREV;
      else op = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
      if (live.size() != 0 && $urandom_range(99) < 85) begin
        hi = IDX_W'(live[$urandom_range(live.size() - 1)]);
        hg = slot_gen[hi];
      end else begin
        case ($urandom_range(2))
          0: hg = slot_gen[hi];
          1: hg = slot_gen[hi] - 1'b1;
          default: hg = GEN_W'($urandom);
        endcase
      end
    end else begin
      op = 3'($urandom_range(7));
    end
  endtask

  // Response ready. A hold-off request from the main sequence keeps ready low
  // for a long stretch while requests keep coming, so that the block backs up
  // and stalls its request side.
  initial begin
    forever begin
      @(negedge clk);
      if (rsp_hold_request) begin
        rsp_hold_request = 1'b0;
        rsp_ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        rsp_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Response checking against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_responses.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected response: status %0d index %0d gen %0d count %0d",
                   status, result_index, result_generation, used_count);
      end else begin
        oldest = expected_responses.pop_front();
        if (status !== oldest.status || result_index !== oldest.slot ||
            result_generation !== oldest.gen || used_count !== oldest.count) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("response mismatch: expected status %0d index %0d gen %0d count %0d, got status %0d index %0d gen %0d count %0d",
                     oldest.status, oldest.slot, oldest.gen, oldest.count,
                     status, result_index, result_generation, used_count);
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on any channel means the
  // block has hung.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("generational_slot_allocator verification failed");
    $finish;
  end

  initial begin
    logic [2:0]       op;
    logic [IDX_W-1:0] hi;
    logic [GEN_W-1:0] hg;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      slot_busy[s] = 1'b0;
      slot_gen[s]  = GEN_RESET;
    end
    free_hint_copy = 1;
    busy_total     = '0;
    active_setting = ACTIVE_RESET;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. From reset nothing is used, so every lookup fails; then
    // two opens, the valid, stale and zero handle cases, walks in both
    // directions, a close that lowers the hint, undecoded kinds, and finally
    // the capacity shrunk under used slots, down to the sizes at which no
    // slot is usable, and the clamped maximum.
    script.push_back(known_row(KIND_CHECK, 0, 0, ST_BAD, 0, 0, 0));
    script.push_back(known_row(KIND_NEXT, 0, 0, ST_NONE, 0, 0, 0));
    script.push_back(known_row(KIND_PREV, 63, GEN_TOP, ST_NONE, 0, 0, 0));
    script.push_back(known_row(KIND_CLOSE, 1, 1, ST_BAD, 0, 0, 0));
    script.push_back(known_row(KIND_OPEN, 0, 0, ST_OK, 1, 1, 1));
    script.push_back(known_row(KIND_OPEN, 63, GEN_TOP, ST_OK, 2, 1, 2));
    script.push_back(known_row(KIND_CHECK, 1, 1, ST_OK, 1, 1, 2));
    script.push_back(known_row(KIND_CHECK, 1, GEN_TOP, ST_BAD, 0, 0, 2));
    script.push_back(known_row(KIND_NEXT, 63, GEN_TOP, ST_OK, 1, 1, 2));
    script.push_back(known_row(KIND_PREV, 2, 0, ST_OK, 1, 1, 2));
    script.push_back(known_row(KIND_PREV, 1, 0, ST_OK, 2, 1, 2));
    script.push_back(known_row(KIND_CLOSE, 1, 1, ST_OK, 0, 0, 1));
    script.push_back(known_row(KIND_CHECK, 1, 1, ST_BAD, 0, 0, 1));
    script.push_back(known_row(KIND_OPEN, 0, 0, ST_OK, 1, 2, 2));
    script.push_back(known_row(KIND_UNUSED_FIRST, 1, 2, ST_BAD, 0, 0, 2));
    script.push_back(known_row(KIND_UNUSED_LAST, 63, GEN_TOP, ST_BAD, 0, 0, 2));
    script.push_back(known_row(KIND_CLOSE, 0, 1, ST_BAD, 0, 0, 2));
    script.push_back(request_row(KIND_CLOSE, 63, GEN_TOP));
    script.push_back(setting_row(2));
    script.push_back(known_row(KIND_CHECK, 2, 1, ST_BAD, 0, 0, 2));
    script.push_back(known_row(KIND_OPEN, 0, 0, ST_NONE, 0, 0, 2));
    script.push_back(known_row(KIND_NEXT, 0, 0, ST_OK, 1, 2, 2));
    script.push_back(known_row(KIND_PREV, 0, 0, ST_OK, 1, 2, 2));
    script.push_back(setting_row(1));
    script.push_back(known_row(KIND_OPEN, 0, 0, ST_NONE, 0, 0, 2));
    script.push_back(known_row(KIND_CLOSE, 1, 2, ST_BAD, 0, 0, 2));
    script.push_back(known_row(KIND_NEXT, 0, 0, ST_NONE, 0, 0, 2));
    script.push_back(setting_row(0));
    script.push_back(known_row(KIND_PREV, 0, 0, ST_NONE, 0, 0, 2));
    script.push_back(setting_row(127));
    script.push_back(request_row(KIND_OPEN, 0, 0));
    script.push_back(request_row(KIND_NEXT, 2, 0));

    foreach (script[n]) begin
      if (script[n].is_setting)
        write_active(script[n].setting);
      else
        offer(script[n].op, script[n].idx, script[n].gen, script[n].typed, script[n].want);
    end

    // Random part. The first phases idle mostly on the response side, the
    // middle ones mostly on the request side and the last ones not at all.
    for (int p = 0; p < 8; p++) begin
      write_active(ACTIVE_W'(phase_setting[p]));
      if (p < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 63;
      end else if (p < 6) begin
        send_idle_pct = 63;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 1) rsp_hold_request = 1'b1;
      for (int n = 0; n < phase_items[p]; n++) begin
        choose_request(op, hi, hg);
        offer(op, hi, hg, 1'b0, '0);
      end
    end
    req_valid <= 1'b0;

    while (expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0) begin
      fault_count++;
      $display("%0d expected responses never arrived", expected_responses.size());
    end

    if (fault_count == 0)
      $display("generational_slot_allocator verification clean");
    else
      $display("generational_slot_allocator verification failed");
    $finish;
  end

endmodule

### files.f
hdl/gsa_pkg.sv
hdl/gsa_gen_store.sv
hdl/gsa_slot_finder.sv
hdl/generational_slot_allocator.sv
test/tb_top.sv
